FILE: rtl/timf_pkg.sv
package timf_pkg;

  localparam int unsigned TsW = 32;
  localparam int unsigned CntW = 16;
  localparam int unsigned QualW = 6;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TsW-1:0] NoiseReset = 32'd4000;
  localparam logic [TsW-1:0] NoQualifyPeriod = 32'd10000000;
  localparam logic [6:0] TolScale = 7'd100;
  localparam logic [2:0] TolPercent = 3'd5;
  localparam logic [CntW-1:0] CntMax = 16'hFFFF;
  localparam logic [QualW-1:0] QualMax = 6'h3F;

  localparam logic [CfgIdxW-1:0] RegNoise = 1'b0;
  localparam logic [CfgIdxW-1:0] RegStrobe = 1'b1;

  localparam logic ModeEdge = 1'b0;
  localparam logic ModeRecompute = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [TsW-1:0]  timestamp;
  } in_item_t;

  typedef struct packed {
    logic [TsW-1:0]   expected_period;
    logic [CntW-1:0]  turn_mark_count;
    logic [CntW-1:0]  mark_count;
    logic             strobe_level;
    logic             interval_accepted;
    logic [QualW-1:0] qualified_count;
  } out_item_t;

  // Divider start/result group
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

FILE: rtl/timf_if.sv
interface timf_in_if;
  logic               valid;
  logic               ready;
  timf_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface timf_out_if;
  logic                valid;
  logic                ready;
  timf_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/tacho_interval_median_filter.sv
// Channel  | Dir | Payload
// in_if    | in  | mode, timestamp
// out_if   | out | expected_period, turn_mark_count, mark_count, strobe_level,
//          |     | interval_accepted, qualified_count
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i
// After reset a clearing pass writes zero to every ring entry.
// An edge item goes through accept, update and ring write, then the result register.
// A recompute item runs a rank count that reads the ring once per candidate,
// a tolerance pass, and a bit-serial divide that is skipped when nothing qualifies;
// the single ring read port sets the length of the rank count and the tolerance pass.
// The next item is taken once the result register is loaded; a result still waiting
// there holds the following item in its output state.
module tacho_interval_median_filter #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  timf_in_if.sink              in_if,
  timf_out_if.source           out_if,
  input  logic                 cfg_we_i,
  input  logic [timf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);
  localparam int unsigned AddrW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SumW = 32 + CW;
  localparam int unsigned MedRank = RING_DEPTH / 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EDGE, S_RANK_RD, S_RANK_CMP, S_QUAL, S_QUAL_LAST,
    S_DIV_START, S_DIV_WAIT, S_OUT
  } state_e;

  state_e state_q;

  // ring memory, one read and one write port
  logic [31:0] ring_mem [RING_DEPTH];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= ring_mem[mem_raddr];
  end

  logic [31:0]       noise_q, prev_ts_q, period_q, cand_q, median_q;
  logic [15:0]       strobe_mark_q, marks_q, latched_q;
  logic              prev_valid_q, strobe_q, acc_q;
  logic [AddrW-1:0]  wptr_q;
  logic [timf_pkg::QualW-1:0] qual_q;
  logic [CW-1:0]     idx_q, cnt_gt_q, cnt_ge_q, qcnt_q;
  logic [AddrW-1:0]  cand_idx_q;
  logic              rd_pend_q, cand_phase_q;
  logic [SumW-1:0]   sum_q;
  logic [31:0]       ts_q;
  logic              out_valid_q;
  timf_pkg::out_item_t out_q;

  // interval
  logic [31:0] diff;
  assign diff = (ts_q >= prev_ts_q) ? ts_q - prev_ts_q : prev_ts_q - ts_q;

  logic [34:0] e5;
  logic [32:0] d_ext;
  assign e5 = {3'b0, period_q} + {1'b0, period_q, 2'b0};
  assign d_ext = {1'b0, diff};
  logic gt_turn, gt_mark;
  assign gt_turn = {2'b0, d_ext} > {2'b0, e5[34:2]};
  // d > floor(E/3)  <=>  d >= floor(E/3)+1  <=>  3d > E - (E mod 3) ... use 3d >= E+1 - ?:
  // floor(E/3) < d  <=>  E/3 < d  <=>  E < 3d (integers)
  logic [33:0] d3;
  assign d3 = {2'b0, diff} + {1'b0, diff, 1'b0};
  assign gt_mark = d3 > {2'b0, period_q};

  // tolerance: 100*|v-m| < 5*m  (equivalent to floor(100*|v-m|/m) < 5)
  logic [31:0] vdiff;
  logic [38:0] lhs, rhs;
  assign vdiff = (mem_rdata_q >= median_q) ? mem_rdata_q - median_q
                                           : median_q - mem_rdata_q;
  assign lhs = 39'(vdiff) * 39'(timf_pkg::TolScale);
  assign rhs = 39'(median_q) * 39'(timf_pkg::TolPercent);

  // divider, started only when something qualified
  timf_pkg::div_ctl_t div_ctl;
  logic [SumW-1:0] quo;
  timf_div #(.NumW(SumW), .DenW(CW)) u_div (
    .clk_i, .rst_ni, .start_i(div_ctl.start), .num_i(sum_q), .den_i(qcnt_q),
    .busy_o(div_ctl.busy), .done_o(div_ctl.done), .quo_o(quo)
  );
  assign div_ctl.start = (state_q == S_DIV_START) && (qcnt_q != '0);

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.payload = out_q;

  // memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = wptr_q;
    mem_wdata = diff;
    mem_raddr = cand_idx_q;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = idx_q[AddrW-1:0];
      mem_wdata = '0;
    end else if (state_q == S_EDGE) begin
      mem_we = prev_valid_q && (diff > noise_q);
    end
    if (state_q == S_RANK_RD) begin
      mem_raddr = (rd_pend_q && !cand_phase_q) ? idx_q[AddrW-1:0] : cand_idx_q;
    end else if (state_q == S_RANK_CMP || state_q == S_QUAL) begin
      mem_raddr = idx_q[AddrW-1:0];
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= timf_pkg::NoiseReset;
      strobe_mark_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        timf_pkg::RegNoise:  noise_q <= cfg_wdata_i;
        timf_pkg::RegStrobe: strobe_mark_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Rank search: for each candidate c, count entries > c (gt) and >= c (ge).
  // The median is the c with gt <= MedRank < ge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q <= '0;
      wptr_q <= '0;
      prev_ts_q <= '0;
      prev_valid_q <= 1'b0;
      period_q <= '0;
      marks_q <= '0;
      latched_q <= '0;
      strobe_q <= 1'b0;
      qual_q <= '0;
      acc_q <= 1'b0;
      out_valid_q <= 1'b0;
      cand_idx_q <= '0;
      rd_pend_q <= 1'b0;
      cand_phase_q <= 1'b0;
      cnt_gt_q <= '0;
      cnt_ge_q <= '0;
      qcnt_q <= '0;
      ts_q <= '0;
      cand_q <= '0;
      median_q <= '0;
      sum_q <= '0;
      out_q <= '0;
    end else begin
      // drop the result once taken, unless a new one is loaded now
      if (out_if.valid && out_if.ready && state_q != S_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == CW'(RING_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_if.valid) begin
            ts_q <= in_if.payload.timestamp;
            acc_q <= 1'b0;
            if (in_if.payload.mode == timf_pkg::ModeRecompute) begin
              cand_idx_q <= '0;
              idx_q <= '0;
              cand_phase_q <= 1'b1;
              rd_pend_q <= 1'b0;
              state_q <= S_RANK_RD;
            end else begin
              state_q <= S_EDGE;
            end
          end
        end
        S_EDGE: begin
          if (prev_valid_q && diff > noise_q) begin
            acc_q <= 1'b1;
            wptr_q <= (wptr_q == AddrW'(RING_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
            if (gt_turn) latched_q <= marks_q;
            if (gt_mark) begin
              strobe_q <= ((gt_turn ? 16'd0 : marks_q) == strobe_mark_q);
              if (gt_turn) marks_q <= 16'd1;
              else if (marks_q != timf_pkg::CntMax) marks_q <= marks_q + 1'b1;
            end else if (gt_turn) begin
              marks_q <= '0;
            end
          end
          prev_ts_q <= ts_q;
          prev_valid_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_RANK_RD: begin
          // candidate read issued in phase 1, sweep reads follow
          if (cand_phase_q) begin
            cand_phase_q <= 1'b0;
            rd_pend_q <= 1'b1;
            idx_q <= '0;
            cnt_gt_q <= '0;
            cnt_ge_q <= '0;
          end else begin
            if (rd_pend_q && idx_q == '0) cand_q <= mem_rdata_q;
            state_q <= S_RANK_CMP;
            idx_q <= idx_q + 1'b1;
          end
        end
        S_RANK_CMP: begin
          if (mem_rdata_q > cand_q) cnt_gt_q <= cnt_gt_q + 1'b1;
          if (mem_rdata_q >= cand_q) cnt_ge_q <= cnt_ge_q + 1'b1;
          if (idx_q == CW'(RING_DEPTH)) begin
            // decide on this candidate after its final compare
            if ((cnt_gt_q + CW'(mem_rdata_q > cand_q)) <= CW'(MedRank) &&
                (cnt_ge_q + CW'(mem_rdata_q >= cand_q)) > CW'(MedRank)) begin
              median_q <= cand_q;
              state_q <= S_QUAL;
              idx_q <= '0;
              rd_pend_q <= 1'b1;
              sum_q <= '0;
              qcnt_q <= '0;
            end else begin
              state_q <= S_RANK_RD;
              cand_phase_q <= 1'b1;
              idx_q <= '0;
              rd_pend_q <= 1'b0;
              cand_idx_q <= cand_idx_q + 1'b1;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_QUAL: begin
          // first cycle only primes the read
          if (rd_pend_q) begin
            rd_pend_q <= 1'b0;
          end else begin
            if (median_q != '0 && lhs < rhs) begin
              sum_q <= sum_q + SumW'(mem_rdata_q);
              qcnt_q <= qcnt_q + 1'b1;
            end
          end
          if (idx_q == CW'(RING_DEPTH - 1) && !rd_pend_q) state_q <= S_QUAL_LAST;
          else if (!rd_pend_q || idx_q == '0) idx_q <= rd_pend_q ? idx_q + 1'b1 : idx_q + 1'b1;
        end
        S_QUAL_LAST: begin
          if (median_q != '0 && lhs < rhs) begin
            sum_q <= sum_q + SumW'(mem_rdata_q);
            qcnt_q <= qcnt_q + 1'b1;
          end
          state_q <= S_DIV_START;
        end
        S_DIV_START: begin
          if (qcnt_q == '0) begin
            period_q <= timf_pkg::NoQualifyPeriod;
            qual_q <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_ctl.done) begin
            period_q <= quo[31:0];
            qual_q <= (qcnt_q > CW'(timf_pkg::QualMax)) ? timf_pkg::QualMax
                                                         : (timf_pkg::QualW)'(qcnt_q);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_q.expected_period <= period_q;
            out_q.turn_mark_count <= latched_q;
            out_q.mark_count <= marks_q;
            out_q.strobe_level <= strobe_q;
            out_q.interval_accepted <= acc_q;
            out_q.qualified_count <= qual_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // write pointer stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wptr_q <= AddrW'(RING_DEPTH - 1)) else $error("ring pointer out of range");
  // no item taken while clearing or working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  // divider only runs in its wait state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.busy |-> state_q == S_DIV_WAIT) else $error("divider busy out of place");
endmodule

FILE: rtl/timf_div.sv
// Restoring divider, one quotient bit per cycle
module timf_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned StepW = $clog2(NumW + 1);

  logic [NumW-1:0]  quo_q, quo_d;
  logic [DenW:0]    rem_q, rem_d;
  logic [DenW-1:0]  den_q, den_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DenW:0]    trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      step_d = StepW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit and try a subtract
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule
